// File: rtl/button_edge_chord_tracker_unit_defines.svh
// ----------------------------------------------------------------------------
// button edge chord tracker assertion macros
// clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef BUTTON_EDGE_CHORD_TRACKER_UNIT_DEFINES_SVH
`define BUTTON_EDGE_CHORD_TRACKER_UNIT_DEFINES_SVH

// consequent checked in the same cycle
`define BECT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define BECT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bect_pkg.sv
// ----------------------------------------------------------------------------
// bect_pkg
// types, codes and chord fold helpers for the button edge chord tracker
// ----------------------------------------------------------------------------
package bect_pkg;

    localparam int REQ_W  = 2;
    localparam int WORD_W = 16;
    localparam int TICK_W = 32;
    localparam int WIN_W  = 32;
    localparam int STAT_W = 32;

    typedef logic [1:0]      t_btn;
    typedef logic [3:0][1:0] t_map;

    localparam t_btn ST_UP       = 2'd0;
    localparam t_btn ST_PUSHED   = 2'd1;
    localparam t_btn ST_DOWN     = 2'd2;
    localparam t_btn ST_RELEASED = 2'd3;

    localparam logic [REQ_W-1:0] REQ_REPORT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SETTLE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    localparam logic CFG_BUFFERED = 1'b0;
    localparam logic CFG_PRESENT  = 1'b1;

    localparam logic [WORD_W-1:0] PRESENT_RESET = 16'h9F1F;

    localparam t_map MAP_IDENT = {ST_RELEASED, ST_DOWN, ST_PUSHED, ST_UP};

    // effect of one later chord member on the running result
    function automatic t_map step_map(input t_btn s);
        t_map m;
        m = MAP_IDENT;
        case (s)
            ST_UP: begin
                m = {ST_UP, ST_UP, ST_UP, ST_UP};
            end
            ST_DOWN: begin
                m[ST_PUSHED] = ST_DOWN;
            end
            ST_RELEASED: begin
                m[ST_UP]     = ST_UP;
                m[ST_PUSHED] = ST_UP;
                m[ST_DOWN]   = ST_UP;
            end
            default: begin
                m = MAP_IDENT;
            end
        endcase
        return m;
    endfunction

    // apply a first, then b
    function automatic t_map compose(input t_map a, input t_map b);
        t_map c;
        for (int x = 0; x < 4; x++) begin
            c[x] = b[a[x]];
        end
        return c;
    endfunction

endpackage

// File: rtl/button_edge_chord_tracker_unit.sv
// ----------------------------------------------------------------------------
// button_edge_chord_tracker_unit
// per-button press/release trackers with end-of-frame settle and chord query
// ----------------------------------------------------------------------------
// s_axis carries one request per beat: tuser is the request kind (report,
// end-of-frame settle, query), tdata the button word, tick, query mask and
// error window. every request yields exactly one m_axis beat with the
// changed mask, the packed tracker states and the query result.
// a beat is taken into an input register, processed against the tracker
// state and placed in the output register when that register is free or
// is being read out. one request is accepted per cycle while m_axis does
// not stall; the per-button step, window compare and a four-level tree of
// state maps all fit in the single processing stage.
// when m_axis stalls the output register holds its beat and the input
// register fills; s_axis_tready drops only when both are full.
// the user writes configuration (buffered mode, present mask) via i_cfg_we,
// i_cfg_idx, i_cfg_data only while no request is in flight; unenforced.
// reset (synchronous, active low) sets all trackers to up, edge ticks to
// zero, buffered mode off, present mask 0x9f1f, and empties both registers.
// ----------------------------------------------------------------------------
`include "button_edge_chord_tracker_unit_defines.svh"

module button_edge_chord_tracker_unit
    import bect_pkg::*;
#(
    parameter int BUTTON_BITS = 16,
    parameter int TICK_WIDTH  = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // button_word, now_tick, query_mask, error_window
    input  logic [95:0]       s_axis_tdata,
    // req_type
    input  logic [REQ_W-1:0]  s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // changed_mask, status_vector, query_status, query_down, zero pad
    output logic [55:0]       m_axis_tdata,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [WORD_W-1:0] i_cfg_data
);

    localparam int NB = (BUTTON_BITS < WORD_W) ? BUTTON_BITS : WORD_W;
    localparam int CW = (TICK_WIDTH > WIN_W) ? TICK_WIDTH : WIN_W;

    logic                  r_in_vld;
    logic [REQ_W-1:0]      r_in_req;
    logic [WORD_W-1:0]     r_in_word;
    logic [TICK_W-1:0]     r_in_now;
    logic [WORD_W-1:0]     r_in_qmask;
    logic [WIN_W-1:0]      r_in_win;

    t_btn                  r_state [NB];
    t_btn                  n_state [NB];
    logic [TICK_WIDTH-1:0] r_edge  [NB];
    logic [TICK_WIDTH-1:0] n_edge  [NB];
    logic                  r_seen;
    logic                  n_seen;
    logic                  r_buf;
    logic [WORD_W-1:0]     r_present;

    logic                  r_out_vld;
    logic [WORD_W-1:0]     r_out_changed;
    logic [STAT_W-1:0]     r_out_status;
    t_btn                  r_out_qstat;
    logic                  r_out_qdown;

    logic                  w_proc;
    logic [WORD_W-1:0]     w_changed;
    logic [STAT_W-1:0]     w_status;
    logic [TICK_WIDTH-1:0] w_now;
    logic [CW-1:0]         w_now_ext;
    logic [WORD_W-1:0]     w_qm;
    logic [WORD_W-1:0]     w_vis;
    logic [WORD_W-1:0]     w_first;
    logic                  w_single;
    t_btn                  w_single_res;
    t_btn                  w_eff   [NB];
    t_btn                  w_sfirst;
    t_map                  w_lv0   [16];
    t_map                  w_lv1   [8];
    t_map                  w_lv2   [4];
    t_map                  w_lv3   [2];
    t_map                  w_total;
    t_btn                  w_multi_res;
    t_btn                  w_qstat;
    logic                  w_no_trans;

    assign w_proc        = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_proc;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'd0, r_out_qdown, r_out_qstat, r_out_status, r_out_changed};

    assign w_now_ext = CW'(r_in_now);
    assign w_now     = w_now_ext[TICK_WIDTH-1:0];

    // report and settle steps
    always_comb begin
        n_state   = r_state;
        n_edge    = r_edge;
        n_seen    = r_seen;
        w_changed = '0;
        case (r_in_req)
            REQ_REPORT: begin
                n_seen = 1'b1;
                for (int i = 0; i < NB; i++) begin
                    if (r_present[i]) begin
                        unique case (r_state[i])
                            ST_UP: begin
                                if (r_in_word[i]) begin
                                    n_state[i] = r_buf ? ST_PUSHED : ST_DOWN;
                                    if (r_buf) begin
                                        n_edge[i] = w_now;
                                    end
                                end
                            end
                            ST_PUSHED: begin
                                n_state[i] = r_in_word[i] ? ST_DOWN : ST_RELEASED;
                            end
                            ST_DOWN: begin
                                if (!r_in_word[i]) begin
                                    n_state[i] = r_buf ? ST_RELEASED : ST_UP;
                                    if (r_buf) begin
                                        n_edge[i] = w_now;
                                    end
                                end
                            end
                            default: begin
                                n_state[i] = r_in_word[i] ? ST_PUSHED : ST_UP;
                            end
                        endcase
                    end
                    w_changed[i] = (n_state[i] != r_state[i]);
                end
            end
            REQ_SETTLE: begin
                n_seen = 1'b0;
                if (!r_seen) begin
                    for (int i = 0; i < NB; i++) begin
                        if (r_state[i] == ST_PUSHED) begin
                            n_state[i] = ST_DOWN;
                        end else if (r_state[i] == ST_RELEASED) begin
                            n_state[i] = ST_UP;
                        end
                        w_changed[i] = (n_state[i] != r_state[i]);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_status   = '0;
        w_no_trans = 1'b1;
        for (int i = 0; i < NB; i++) begin
            w_status[2*i +: 2] = n_state[i];
            if (r_state[i] == ST_PUSHED || r_state[i] == ST_RELEASED) begin
                w_no_trans = 1'b0;
            end
        end
    end

    // query: single button lookup or chord fold
    always_comb begin
        logic [WORD_W-1:0]     lower;
        logic [TICK_WIDTH-1:0] diff;
        w_qm         = '0;
        w_vis        = '0;
        w_first      = '0;
        w_single_res = ST_UP;
        w_sfirst     = ST_UP;
        lower        = '0;
        for (int i = 0; i < NB; i++) begin
            w_qm[i]  = r_in_qmask[i];
            w_vis[i] = r_in_qmask[i] & r_present[i];
        end
        w_single = (w_qm != '0) && ((w_qm & (w_qm - 1'b1)) == '0);
        for (int i = 0; i < 16; i++) begin
            w_lv0[i] = MAP_IDENT;
        end
        for (int i = 0; i < NB; i++) begin
            if (w_qm[i] && r_present[i]) begin
                w_single_res = r_state[i];
            end
            diff     = w_now - r_edge[i];
            w_eff[i] = r_state[i];
            if (r_in_win != '0 && CW'(diff) <= CW'(r_in_win)) begin
                if (r_state[i] == ST_DOWN) begin
                    w_eff[i] = ST_PUSHED;
                end else if (r_state[i] == ST_UP) begin
                    w_eff[i] = ST_RELEASED;
                end
            end
            w_first[i] = w_vis[i] && (lower == '0);
            lower[i]   = w_vis[i];
            if (w_first[i]) begin
                w_sfirst = w_eff[i];
            end
            if (w_vis[i] && !w_first[i]) begin
                w_lv0[i] = step_map(w_eff[i]);
            end
        end
        for (int k = 0; k < 8; k++) begin
            w_lv1[k] = compose(w_lv0[2*k], w_lv0[2*k+1]);
        end
        for (int k = 0; k < 4; k++) begin
            w_lv2[k] = compose(w_lv1[2*k], w_lv1[2*k+1]);
        end
        for (int k = 0; k < 2; k++) begin
            w_lv3[k] = compose(w_lv2[2*k], w_lv2[2*k+1]);
        end
        w_total     = compose(w_lv3[0], w_lv3[1]);
        w_multi_res = (w_vis != '0) ? w_total[w_sfirst] : ST_UP;
        if (r_in_req != REQ_QUERY || w_qm == '0) begin
            w_qstat = ST_UP;
        end else if (w_single) begin
            w_qstat = w_single_res;
        end else begin
            w_qstat = w_multi_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_seen    <= 1'b0;
            r_buf     <= 1'b0;
            r_present <= PRESENT_RESET;
            for (int i = 0; i < NB; i++) begin
                r_state[i] <= ST_UP;
                r_edge[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BUFFERED: r_buf     <= i_cfg_data[0];
                    default:      r_present <= i_cfg_data;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_vld   <= 1'b1;
                r_in_req   <= s_axis_tuser;
                r_in_word  <= s_axis_tdata[15:0];
                r_in_now   <= s_axis_tdata[47:16];
                r_in_qmask <= s_axis_tdata[63:48];
                r_in_win   <= s_axis_tdata[95:64];
            end else if (w_proc) begin
                r_in_vld <= 1'b0;
            end
            if (w_proc) begin
                r_state       <= n_state;
                r_edge        <= n_edge;
                r_seen        <= n_seen;
                r_out_vld     <= 1'b1;
                r_out_changed <= w_changed;
                r_out_status  <= w_status;
                r_out_qstat   <= w_qstat;
                r_out_qdown   <= (w_qstat != ST_UP);
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    `BECT_ASSERT_NEXT(a_unbuf_no_transient, w_proc && !r_buf && w_no_trans, w_no_trans, "transient state reached in unbuffered mode")
    `BECT_ASSERT_NEXT(a_nonquery_up, w_proc && r_in_req != REQ_QUERY, r_out_qstat == ST_UP && !r_out_qdown, "query result set on non-query request")
    `BECT_ASSERT_NEXT(a_settle_after_report, w_proc && r_in_req == REQ_SETTLE && r_seen, r_out_changed == '0 && !r_seen, "settle changed state after a report")
    `BECT_ASSERT_NEXT(a_result_follows, w_proc, r_out_vld, "processed request produced no result")
    `BECT_ASSERT_SAME(a_ready_when_empty, !r_in_vld, s_axis_tready, "input register empty but not ready")

endmodule
